// ----- rtl/bubble_sort_ascending_macros.svh -----
// Assertion macros shared by the bubble sort RTL.
// No dependencies; included by modules that carry assertions.
`ifndef BUBBLE_SORT_ASCENDING_MACROS_SVH
`define BUBBLE_SORT_ASCENDING_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define BSA_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset.
`define BSA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/bsa_pkg.sv -----
// Package for the bubble sort block: command and status structs
// between controller and datapath. No dependencies.
package bsa_pkg;

  typedef struct packed {
    logic load;       // shift new element into the row
    logic sort_step;  // one odd-even compare-exchange phase
    logic emit_step;  // output transfer, shift row down
    logic finish;     // final element taken, clear counters
  } cmd_t;

  typedef struct packed {
    logic will_fill;  // next load fills the store
    logic sort_last;  // current phase is the last one
    logic emit_last;  // element at the head is the final one
  } stat_t;

endpackage

// ----- rtl/bsa_datapath.sv -----
// Datapath for the bubble sort block: element row, compare-exchange
// cells and counters. Depends on bsa_pkg.
module bsa_datapath #(
  parameter int MAX_ITEMS = 64
) (
  input  logic                clk,
  input  logic                rst,
  input  bsa_pkg::cmd_t       cmd,
  input  logic signed [31:0]  value,
  output logic signed [31:0]  sorted_value,
  output logic                final_res,
  output bsa_pkg::stat_t      stat
);
  import bsa_pkg::*;

  localparam int CNT_W = $clog2(MAX_ITEMS + 1);
  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_ITEMS);

  logic signed [31:0] elem [MAX_ITEMS];
  logic signed [31:0] sort_next [MAX_ITEMS];
  logic [CNT_W-1:0]   count;
  logic [CNT_W-1:0]   phase;
  logic [CNT_W-1:0]   emitted;

  // one phase of odd-even transposition over the loaded part of the row
  always_comb begin
    sort_next = elem;
    for (int k = 0; k < MAX_ITEMS - 1; k++) begin
      if (((k % 2) == int'(phase[0])) && (CNT_W'(k + 1) < count) &&
          (elem[k] > elem[k + 1])) begin
        sort_next[k]     = elem[k + 1];
        sort_next[k + 1] = elem[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      elem[0] <= value;
      for (int k = 1; k < MAX_ITEMS; k++) begin
        elem[k] <= elem[k - 1];
      end
    end else if (cmd.sort_step) begin
      elem <= sort_next;
    end else if (cmd.emit_step) begin
      for (int k = 0; k < MAX_ITEMS - 1; k++) begin
        elem[k] <= elem[k + 1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.finish) begin
      count   <= '0;
      phase   <= '0;
      emitted <= '0;
    end else begin
      if (cmd.load) begin
        count <= count + 1'b1;
      end
      if (cmd.sort_step) begin
        phase <= phase + 1'b1;
      end
      if (cmd.emit_step) begin
        emitted <= emitted + 1'b1;
      end
    end
  end

  assign stat.will_fill = ((count + 1'b1) == MAX_CNT);
  assign stat.sort_last = ((phase + 1'b1) >= count);
  assign stat.emit_last = ((emitted + 1'b1) == count);

  assign sorted_value = elem[0];
  assign final_res    = stat.emit_last;

endmodule

// ----- rtl/bsa_ctrl.sv -----
// Controller for the bubble sort block: load, sort and emit sequencing.
// Depends on bsa_pkg and bubble_sort_ascending_macros.svh.
`include "bubble_sort_ascending_macros.svh"
module bsa_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            s_tvalid,
  input  logic            s_tlast,
  output logic            s_tready,
  output logic            m_tvalid,
  input  logic            m_tready,
  input  bsa_pkg::stat_t  stat,
  output bsa_pkg::cmd_t   cmd
);
  import bsa_pkg::*;

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_SORT,
    ST_EMIT
  } state_t;

  state_t state;

  assign cmd.load      = s_tvalid && s_tready;
  assign cmd.sort_step = (state == ST_SORT);
  assign cmd.emit_step = m_tvalid && m_tready;
  assign cmd.finish    = cmd.emit_step && stat.emit_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_LOAD;
      s_tready <= 1'b1;
      m_tvalid <= 1'b0;
    end else begin
      case (state)
        ST_LOAD: begin
          if (cmd.load && (s_tlast || stat.will_fill)) begin
            state    <= ST_SORT;
            s_tready <= 1'b0;
          end
        end
        ST_SORT: begin
          if (stat.sort_last) begin
            state    <= ST_EMIT;
            m_tvalid <= 1'b1;
          end
        end
        ST_EMIT: begin
          if (cmd.finish) begin
            state    <= ST_LOAD;
            m_tvalid <= 1'b0;
            s_tready <= 1'b1;
          end
        end
        default: begin
          state    <= ST_LOAD;
          s_tready <= 1'b1;
          m_tvalid <= 1'b0;
        end
      endcase
    end
  end

  `BSA_ASSERT_NOW(a_sides_exclusive, 1'b1, !(s_tready && m_tvalid), "load and emit overlap")
  `BSA_ASSERT_NEXT(a_close_set, cmd.load && s_tlast, !s_tready && (state == ST_SORT), "set end not taken")
  `BSA_ASSERT_NEXT(a_reopen, cmd.finish, s_tready && !m_tvalid, "no return to load after final transfer")

endmodule

// ----- rtl/bubble_sort_ascending.sv -----
// Top level of the bubble sort block: stream ports, controller and datapath.
// Depends on bsa_pkg, bsa_ctrl and bsa_datapath.
//
//   channel | dir | tdata              | tlast
//   s_*     | in  | [31:0] value       | last
//   m_*     | out | [31:0] sorted_value| final_res
//
// A set of elements is loaded, then sorted (one odd-even compare-exchange
// phase per cycle across the element row), then emitted.
// Input is accepted only while loading; the output side is offered only
// while emitting. A stalled output holds its transfer and the row.
// Synchronous reset returns to loading with an empty store.
module bubble_sort_ascending #(
  parameter int MAX_ITEMS = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // [31:0] value
  input  logic        s_tlast,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // [31:0] sorted_value
  output logic        m_tlast
);
  import bsa_pkg::*;

  cmd_t               cmd;
  stat_t              stat;
  logic signed [31:0] sorted_value;

  bsa_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tlast  (s_tlast),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  bsa_datapath #(
    .MAX_ITEMS (MAX_ITEMS)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .value        ($signed(s_tdata)),
    .sorted_value (sorted_value),
    .final_res    (m_tlast),
    .stat         (stat)
  );

  assign m_tdata = $unsigned(sorted_value);

endmodule
